@@ rtl/core/pfss_pkg.sv @@
// Package with the shared widths, constants, codes and command types of the flux sweep.
package pfss_pkg;

    localparam int SAT_W     = 17;
    localparam int PRESS_W   = 19;
    localparam int DELTA_W   = 19;
    localparam int COL_W     = 9;
    localparam int PERM_W    = 16;
    localparam int FLOW_W    = 21;
    localparam int MUL_A_W   = 21;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SUM_W     = 22;
    localparam int CNT_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int PHASES    = 3;
    localparam int FRAC_W    = 16;

    localparam logic [SAT_W-1:0]  SAT_MAX     = 17'd131071;
    localparam logic [PERM_W-1:0] HPERM_RESET = 16'd26214;
    localparam logic [PERM_W-1:0] VPERM_RESET = 16'd6554;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = 39'sd32768;
    localparam logic signed [PROD_W-1:0] DELTA_HI   = 39'sd262143;
    localparam logic signed [PROD_W-1:0] DELTA_LO   = -39'sd262144;

    localparam logic [CNT_W-1:0] CALC_LAST = 4'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_HPERM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VPERM = 2'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_CALC,
        ST_FINAL
    } t_state;

    typedef enum logic [2:0] {
        STEP_FU,
        STEP_FV,
        STEP_DU_G,
        STEP_DU_O,
        STEP_DU_W,
        STEP_DV_G,
        STEP_DV_O,
        STEP_DV_W
    } t_step;

    typedef struct packed {
        logic             load;
        logic             mod_en;
        logic             rd_en;
        logic             mul_en;
        t_step            mul_step;
        logic             rnd_en;
        t_step            rnd_step;
        logic             fin_en;
        logic             clr_en;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic out_full;
    } t_status;

endpackage

@@ rtl/core/pfss_ctrl.sv @@
// Controller state machine that sequences the clearing pass and each cell update.
module pfss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pfss_pkg::t_status i_status,
    output pfss_pkg::t_cmd    o_cmd
);
    import pfss_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            ST_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_MOD;
                    n_cnt   = '0;
                end
            end
            ST_MOD: begin
                n_state = ST_CALC;
            end
            ST_CALC: begin
                if (r_cnt == CALC_LAST) begin
                    n_state = ST_FINAL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FINAL: begin
                if (!i_status.out_full) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            ST_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            ST_MOD: begin
                o_cmd.mod_en = 1'b1;
            end
            ST_CALC: begin
                o_cmd.rd_en    = (r_cnt == '0);
                o_cmd.mul_en   = (r_cnt != CALC_LAST);
                o_cmd.mul_step = t_step'(r_cnt[2:0]);
                o_cmd.rnd_en   = (r_cnt != '0);
                o_cmd.rnd_step = t_step'(3'(r_cnt - 1'b1));
            end
            ST_FINAL: begin
                o_cmd.fin_en = !i_status.out_full;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.fin_en |-> !i_status.out_full)
        else $error("Cell finished into an occupied output register.");

    a_load_starts_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.mod_en)
        else $error("Accepted beat did not start the column reduction.");

endmodule

@@ rtl/core/pfss_datapath.sv @@
// Datapath with configuration, column reduction, shared multiplier, line store and output register.
module pfss_datapath #(
    parameter int MAX_COLUMNS = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  pfss_pkg::t_cmd                   i_cmd,
    output pfss_pkg::t_status                o_status,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pfss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pfss_pkg::PERM_W-1:0]      i_cfg_data,
    input  logic [pfss_pkg::COL_W-1:0]       i_column,
    input  logic [pfss_pkg::SAT_W-1:0]       i_cell_gas,
    input  logic [pfss_pkg::SAT_W-1:0]       i_cell_oil,
    input  logic [pfss_pkg::SAT_W-1:0]       i_cell_water,
    input  logic [pfss_pkg::SAT_W-1:0]       i_right_gas,
    input  logic [pfss_pkg::SAT_W-1:0]       i_right_oil,
    input  logic [pfss_pkg::SAT_W-1:0]       i_right_water,
    input  logic [pfss_pkg::SAT_W-1:0]       i_below_gas,
    input  logic [pfss_pkg::SAT_W-1:0]       i_below_oil,
    input  logic [pfss_pkg::SAT_W-1:0]       i_below_water,
    input  logic                             i_right_open,
    input  logic                             i_below_open,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pfss_pkg::SAT_W-1:0]       o_new_gas,
    output logic [pfss_pkg::SAT_W-1:0]       o_new_oil,
    output logic [pfss_pkg::SAT_W-1:0]       o_new_water,
    output logic [pfss_pkg::PRESS_W-1:0]     o_new_pressure
);
    import pfss_pkg::*;

    localparam int ADDR_W   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int LINE_W   = DELTA_W * PHASES;
    localparam int PH_W     = $clog2(PHASES);
    localparam int RECIP_SH = COL_W + ADDR_W;
    localparam int RECIP_W  = COL_W + 2;
    localparam int QPROD_W  = COL_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(MAX_COLUMNS) - 64'd1) / 64'(MAX_COLUMNS));

    logic [PERM_W-1:0]  r_hperm;
    logic [PERM_W-1:0]  r_vperm;
    logic [COL_W-1:0]   r_rem;
    logic [SAT_W-1:0]   r_cell  [PHASES];
    logic [SAT_W-1:0]   r_right [PHASES];
    logic [SAT_W-1:0]   r_below [PHASES];
    logic               r_right_open;
    logic               r_below_open;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [FLOW_W-1:0]  r_fu;
    logic signed [FLOW_W-1:0]  r_fv;
    logic signed [DELTA_W-1:0] r_du   [PHASES];
    logic signed [DELTA_W-1:0] r_dv   [PHASES];
    logic signed [DELTA_W-1:0] r_left [PHASES];
    logic [LINE_W-1:0]  r_mem [MAX_COLUMNS];
    logic [LINE_W-1:0]  r_above;
    logic [ADDR_W-1:0]  r_clr_addr;
    logic               r_out_valid;
    logic [SAT_W-1:0]   r_new_sat [PHASES];
    logic [PRESS_W-1:0] r_new_press;

    logic [QPROD_W-1:0]        quo_prod;
    logic [COL_W-1:0]          quo;
    logic [QPROD_W-1:0]        quo_mul;
    logic [COL_W-1:0]          rem_w;
    logic [ADDR_W-1:0]         rd_addr;
    logic [PH_W-1:0]           du_idx;
    logic [PH_W-1:0]           dv_idx;
    logic [PRESS_W-1:0]        pc;
    logic [PRESS_W-1:0]        pr;
    logic [PRESS_W-1:0]        pb;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_w;
    logic signed [PROD_W-1:0]  rnd_full;
    logic signed [DELTA_W-1:0] rnd_sat;
    logic signed [SUM_W-1:0]   sum_k   [PHASES];
    logic [SAT_W-1:0]          clamp_k [PHASES];
    logic [PRESS_W-1:0]        press_w;
    logic [LINE_W-1:0]         new_above;
    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [LINE_W-1:0]         mem_wdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hperm <= HPERM_RESET;
            r_vperm <= VPERM_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_HPERM: r_hperm <= i_cfg_data;
                CFG_VPERM: r_vperm <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cell[0]    <= i_cell_gas;
            r_cell[1]    <= i_cell_oil;
            r_cell[2]    <= i_cell_water;
            r_right[0]   <= i_right_gas;
            r_right[1]   <= i_right_oil;
            r_right[2]   <= i_right_water;
            r_below[0]   <= i_below_gas;
            r_below[1]   <= i_below_oil;
            r_below[2]   <= i_below_water;
            r_right_open <= i_right_open;
            r_below_open <= i_below_open;
        end
    end

    // The column is reduced modulo the line depth by a reciprocal multiplication.
    assign quo_prod = QPROD_W'(r_rem) * QPROD_W'(RECIP);
    assign quo      = COL_W'(quo_prod >> RECIP_SH);
    assign quo_mul  = QPROD_W'(quo) * QPROD_W'(MAX_COLUMNS);
    assign rem_w    = COL_W'(QPROD_W'(r_rem) - quo_mul);
    assign rd_addr  = ADDR_W'(r_rem);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= i_column;
        end else if (i_cmd.mod_en) begin
            r_rem <= rem_w;
        end
    end

    assign pc = PRESS_W'(r_cell[0]) + PRESS_W'(r_cell[1]) + PRESS_W'(r_cell[2]);
    assign pr = PRESS_W'(r_right[0]) + PRESS_W'(r_right[1]) + PRESS_W'(r_right[2]);
    assign pb = PRESS_W'(r_below[0]) + PRESS_W'(r_below[1]) + PRESS_W'(r_below[2]);

    assign du_idx = PH_W'(i_cmd.mul_step - STEP_DU_G);
    assign dv_idx = PH_W'(i_cmd.mul_step - STEP_DV_G);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.mul_step)
            STEP_FU: begin
                mul_a = r_right_open ? MUL_A_W'($signed({1'b0, pr}) - $signed({1'b0, pc}))
                                     : '0;
                mul_b = $signed({2'b0, r_hperm});
            end
            STEP_FV: begin
                mul_a = r_below_open ? MUL_A_W'($signed({1'b0, pb}) - $signed({1'b0, pc}))
                                     : '0;
                mul_b = $signed({2'b0, r_vperm});
            end
            STEP_DU_G, STEP_DU_O, STEP_DU_W: begin
                mul_a = r_fu;
                mul_b = $signed({1'b0, r_fu[FLOW_W-1] ? r_cell[du_idx] : r_right[du_idx]});
            end
            STEP_DV_G, STEP_DV_O, STEP_DV_W: begin
                mul_a = r_fv;
                mul_b = $signed({1'b0, r_fv[FLOW_W-1] ? r_cell[dv_idx] : r_below[dv_idx]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_w   = mul_a * mul_b;
    assign rnd_full = (r_prod + ROUND_HALF) >>> FRAC_W;

    always_comb begin
        if (rnd_full > DELTA_HI) begin
            rnd_sat = DELTA_W'(DELTA_HI);
        end else if (rnd_full < DELTA_LO) begin
            rnd_sat = DELTA_W'(DELTA_LO);
        end else begin
            rnd_sat = rnd_full[DELTA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= prod_w;
        end
        if (i_cmd.rnd_en) begin
            case (i_cmd.rnd_step)
                STEP_FU:   r_fu    <= rnd_full[FLOW_W-1:0];
                STEP_FV:   r_fv    <= rnd_full[FLOW_W-1:0];
                STEP_DU_G: r_du[0] <= rnd_sat;
                STEP_DU_O: r_du[1] <= rnd_sat;
                STEP_DU_W: r_du[2] <= rnd_sat;
                STEP_DV_G: r_dv[0] <= rnd_sat;
                STEP_DV_O: r_dv[1] <= rnd_sat;
                STEP_DV_W: r_dv[2] <= rnd_sat;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        press_w = '0;
        for (int k = 0; k < PHASES; k++) begin
            sum_k[k] = $signed({{(SUM_W - SAT_W){1'b0}}, r_cell[k]})
                     + SUM_W'(r_du[k]) - SUM_W'(r_left[k])
                     + SUM_W'(r_dv[k])
                     - SUM_W'($signed(r_above[k*DELTA_W +: DELTA_W]));
            if (sum_k[k] < 0) begin
                clamp_k[k] = '0;
            end else if (sum_k[k] > $signed({{(SUM_W - SAT_W){1'b0}}, SAT_MAX})) begin
                clamp_k[k] = SAT_MAX;
            end else begin
                clamp_k[k] = sum_k[k][SAT_W-1:0];
            end
            press_w = press_w + PRESS_W'(clamp_k[k]);
        end
    end

    assign new_above = {r_dv[2], r_dv[1], r_dv[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PHASES; k++) begin
                r_left[k] <= '0;
            end
        end else if (i_cmd.fin_en) begin
            r_left <= r_du;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign mem_we    = i_cmd.clr_en || i_cmd.fin_en;
    assign mem_waddr = i_cmd.clr_en ? r_clr_addr : rd_addr;
    assign mem_wdata = i_cmd.clr_en ? '0 : new_above;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_en) begin
            r_above <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin_en) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin_en) begin
            r_new_sat   <= clamp_k;
            r_new_press <= press_w;
        end
    end

    assign o_status.clr_last = (r_clr_addr == ADDR_W'(MAX_COLUMNS - 1));
    assign o_status.out_full = r_out_valid && !i_ready;

    assign o_valid        = r_out_valid;
    assign o_new_gas      = r_new_sat[0];
    assign o_new_oil      = r_new_sat[1];
    assign o_new_water    = r_new_sat[2];
    assign o_new_pressure = r_new_press;

    a_rem_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> (QPROD_W'(r_rem) < QPROD_W'(MAX_COLUMNS)))
        else $error("Line store address not reduced below the line depth.");

    a_fin_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_en |=> r_out_valid)
        else $error("Finished cell did not raise the output beat.");

endmodule

@@ rtl/core/porous_flux_saturation_sweep_top.sv @@
// Top level of the porous flux sweep: controller and datapath joined by command and status.
//
// Cells enter on the i_valid/o_ready channel, one beat per cell in raster order, and
// results leave on the o_valid/i_ready channel, one beat per cell in the same order.
// The two permeability registers are written on the i_cfg_valid/o_cfg_ready channel,
// which is always ready; index 0 is horizontal and index 1 is vertical.
// After reset a clearing pass writes zero to every line store entry, one per cycle, and
// o_ready stays low during the pass.
// Each cell goes from acceptance to a result beat in order: the idle state takes the
// beat, the next state reduces the column modulo the line depth by a
// reciprocal multiplication, the shared multiplier forms two flows and six
// phase deltas, each product rounded in the following cycle, and a final state
// forms the saturations, writes the line store and loads the output register.
// A new cell is taken only once the previous one has left the final state.
// The output register holds a result while the receiver stalls; the next cell is
// accepted and computed meanwhile, and waits in its last cycle until that
// register is free.
module porous_flux_saturation_sweep_top #(
    parameter int MAX_COLUMNS = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pfss_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pfss_pkg::PERM_W-1:0]      i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [pfss_pkg::COL_W-1:0]       i_column,
    input  logic [pfss_pkg::SAT_W-1:0]       i_cell_gas,
    input  logic [pfss_pkg::SAT_W-1:0]       i_cell_oil,
    input  logic [pfss_pkg::SAT_W-1:0]       i_cell_water,
    input  logic [pfss_pkg::SAT_W-1:0]       i_right_gas,
    input  logic [pfss_pkg::SAT_W-1:0]       i_right_oil,
    input  logic [pfss_pkg::SAT_W-1:0]       i_right_water,
    input  logic [pfss_pkg::SAT_W-1:0]       i_below_gas,
    input  logic [pfss_pkg::SAT_W-1:0]       i_below_oil,
    input  logic [pfss_pkg::SAT_W-1:0]       i_below_water,
    input  logic                             i_right_open,
    input  logic                             i_below_open,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pfss_pkg::SAT_W-1:0]       o_new_gas,
    output logic [pfss_pkg::SAT_W-1:0]       o_new_oil,
    output logic [pfss_pkg::SAT_W-1:0]       o_new_water,
    output logic [pfss_pkg::PRESS_W-1:0]     o_new_pressure
);
    import pfss_pkg::*;

    t_cmd    cmd;
    t_status status;

    pfss_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pfss_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_column       (i_column),
        .i_cell_gas     (i_cell_gas),
        .i_cell_oil     (i_cell_oil),
        .i_cell_water   (i_cell_water),
        .i_right_gas    (i_right_gas),
        .i_right_oil    (i_right_oil),
        .i_right_water  (i_right_water),
        .i_below_gas    (i_below_gas),
        .i_below_oil    (i_below_oil),
        .i_below_water  (i_below_water),
        .i_right_open   (i_right_open),
        .i_below_open   (i_below_open),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_new_gas      (o_new_gas),
        .o_new_oil      (o_new_oil),
        .o_new_water    (o_new_water),
        .o_new_pressure (o_new_pressure)
    );

endmodule

@@ tb/tb_porous_flux_saturation_sweep_top.sv @@
// Self-checking testbench for the porous flux saturation sweep with its own cell predictor.
module tb_porous_flux_saturation_sweep_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pfss_pkg::*;

    localparam int MAX_COLS     = 512;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int END_CYCLES   = 60;
    localparam int HOLD_CYCLES  = 400;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam int GAS   = 0;
    localparam int OIL   = 1;
    localparam int WATER = 2;

    localparam logic [SAT_W-1:0] SAT_ZERO = '0;

    typedef struct packed {
        logic [COL_W-1:0]             column;
        logic [PHASES-1:0][SAT_W-1:0] here_sat;
        logic [PHASES-1:0][SAT_W-1:0] right_sat;
        logic [PHASES-1:0][SAT_W-1:0] below_sat;
        logic                         right_open;
        logic                         below_open;
    } t_porous_cell;

    typedef struct packed {
        logic [PHASES-1:0][SAT_W-1:0] sat;
        logic [PRESS_W-1:0]           pressure;
    } t_sat_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [PERM_W-1:0]    i_cfg_data    = '0;
    logic                 i_valid       = 1'b0;
    logic [COL_W-1:0]     i_column      = '0;
    logic [SAT_W-1:0]     i_cell_gas    = '0;
    logic [SAT_W-1:0]     i_cell_oil    = '0;
    logic [SAT_W-1:0]     i_cell_water  = '0;
    logic [SAT_W-1:0]     i_right_gas   = '0;
    logic [SAT_W-1:0]     i_right_oil   = '0;
    logic [SAT_W-1:0]     i_right_water = '0;
    logic [SAT_W-1:0]     i_below_gas   = '0;
    logic [SAT_W-1:0]     i_below_oil   = '0;
    logic [SAT_W-1:0]     i_below_water = '0;
    logic                 i_right_open  = 1'b0;
    logic                 i_below_open  = 1'b0;
    logic                 i_ready       = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_ready;
    logic                 o_valid;
    logic [SAT_W-1:0]     o_new_gas;
    logic [SAT_W-1:0]     o_new_oil;
    logic [SAT_W-1:0]     o_new_water;
    logic [PRESS_W-1:0]   o_new_pressure;

    logic [PERM_W-1:0] hperm_model = HPERM_RESET;
    logic [PERM_W-1:0] vperm_model = VPERM_RESET;
    longint            left_delta [PHASES];
    longint            above_delta [MAX_COLS][PHASES];

    t_sat_result expected_sats [$];
    int          errors      = 0;
    int          cycle_count = 0;
    bit          no_idle     = 1'b0;
    int          rx_hold     = 0;

    porous_flux_saturation_sweep_top #(
        .MAX_COLUMNS(MAX_COLS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_column      (i_column),
        .i_cell_gas    (i_cell_gas),
        .i_cell_oil    (i_cell_oil),
        .i_cell_water  (i_cell_water),
        .i_right_gas   (i_right_gas),
        .i_right_oil   (i_right_oil),
        .i_right_water (i_right_water),
        .i_below_gas   (i_below_gas),
        .i_below_oil   (i_below_oil),
        .i_below_water (i_below_water),
        .i_right_open  (i_right_open),
        .i_below_open  (i_below_open),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_new_gas     (o_new_gas),
        .o_new_oil     (o_new_oil),
        .o_new_water   (o_new_water),
        .o_new_pressure(o_new_pressure)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        for (int k = 0; k < PHASES; k++) begin
            left_delta[k] = 0;
            for (int c = 0; c < MAX_COLS; c++) begin
                above_delta[c][k] = 0;
            end
        end
    end

    function automatic longint round_q16(longint x);
        return (x + 32768) >>> FRAC_W;
    endfunction

    function automatic longint clamp_delta(longint d);
        if (d > DELTA_HI) begin
            return DELTA_HI;
        end
        if (d < DELTA_LO) begin
            return DELTA_LO;
        end
        return d;
    endfunction

    function automatic t_sat_result sweep_cell(t_porous_cell c);
        longint      p_here;
        longint      p_right;
        longint      p_below;
        longint      fu;
        longint      fv;
        longint      du;
        longint      dv;
        longint      s;
        longint      press;
        longint      out_right [PHASES];
        longint      out_below [PHASES];
        int          col;
        t_sat_result r;
        col = int'(c.column) % MAX_COLS;
        p_here = 0;
        p_right = 0;
        p_below = 0;
        fu = 0;
        fv = 0;
        press = 0;
        r = '0;
        for (int k = 0; k < PHASES; k++) begin
            p_here  += longint'(c.here_sat[k]);
            p_right += longint'(c.right_sat[k]);
            p_below += longint'(c.below_sat[k]);
        end
        if (c.right_open) begin
            fu = round_q16((p_right - p_here) * longint'(hperm_model));
        end
        if (c.below_open) begin
            fv = round_q16((p_below - p_here) * longint'(vperm_model));
        end
        for (int k = 0; k < PHASES; k++) begin
            du = clamp_delta(round_q16(fu * (fu >= 0 ? longint'(c.right_sat[k])
                                                     : longint'(c.here_sat[k]))));
            dv = clamp_delta(round_q16(fv * (fv >= 0 ? longint'(c.below_sat[k])
                                                     : longint'(c.here_sat[k]))));
            s = longint'(c.here_sat[k]) + (du - left_delta[k]) + (dv - above_delta[col][k]);
            if (s < 0) begin
                s = 0;
            end
            if (s > longint'(SAT_MAX)) begin
                s = longint'(SAT_MAX);
            end
            r.sat[k] = s[SAT_W-1:0];
            press += s;
            out_right[k] = du;
            out_below[k] = dv;
        end
        r.pressure = press[PRESS_W-1:0];
        for (int k = 0; k < PHASES; k++) begin
            left_delta[k] = out_right[k];
            above_delta[col][k] = out_below[k];
        end
        return r;
    endfunction

    function automatic void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v,
                     act_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_sat_result e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_sats.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, actual %0d %0d %0d %0d",
                         $time, o_new_gas, o_new_oil, o_new_water, o_new_pressure);
            end else begin
                e = expected_sats.pop_front();
                check_field("new_gas", e.sat[GAS], o_new_gas);
                check_field("new_oil", e.sat[OIL], o_new_oil);
                check_field("new_water", e.sat[WATER], o_new_water);
                check_field("new_pressure", e.pressure, o_new_pressure);
            end
        end
    end

    initial begin
        int n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                n = rx_hold;
                rx_hold = 0;
            end else if (no_idle) begin
                n = 0;
            end else begin
                n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            end
            if (n > 0) begin
                i_ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    function automatic logic [SAT_W-1:0] rand_sat();
        case ($urandom_range(0, 7))
            0:       return SAT_ZERO;
            1:       return SAT_MAX;
            2, 3:    return SAT_W'($urandom_range(0, 30000));
            4:       return SAT_W'($urandom_range(20000, 50000));
            default: return SAT_W'($urandom_range(0, 131071));
        endcase
    endfunction

    function automatic t_porous_cell rand_cell(int col);
        t_porous_cell c;
        c.column = COL_W'(col);
        for (int k = 0; k < PHASES; k++) begin
            c.here_sat[k]  = rand_sat();
            c.right_sat[k] = rand_sat();
            c.below_sat[k] = rand_sat();
        end
        c.right_open = ($urandom_range(0, 7) != 0);
        c.below_open = ($urandom_range(0, 7) != 0);
        return c;
    endfunction

    function automatic t_porous_cell flat_cell(int col, logic [SAT_W-1:0] here,
                                               logic [SAT_W-1:0] right, logic [SAT_W-1:0] below,
                                               logic right_open, logic below_open);
        t_porous_cell c;
        c.column = COL_W'(col);
        for (int k = 0; k < PHASES; k++) begin
            c.here_sat[k]  = here;
            c.right_sat[k] = right;
            c.below_sat[k] = below;
        end
        c.right_open = right_open;
        c.below_open = below_open;
        return c;
    endfunction

    task automatic send_cell(input t_porous_cell c);
        int gap;
        gap = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_column      <= c.column;
        i_cell_gas    <= c.here_sat[GAS];
        i_cell_oil    <= c.here_sat[OIL];
        i_cell_water  <= c.here_sat[WATER];
        i_right_gas   <= c.right_sat[GAS];
        i_right_oil   <= c.right_sat[OIL];
        i_right_water <= c.right_sat[WATER];
        i_below_gas   <= c.below_sat[GAS];
        i_below_oil   <= c.below_sat[OIL];
        i_below_water <= c.below_sat[WATER];
        i_right_open  <= c.right_open;
        i_below_open  <= c.below_open;
        do @(posedge i_clk); while (!o_ready);
        expected_sats.push_back(sweep_cell(c));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_sats.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PERM_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_HPERM: hperm_model = data;
            CFG_VPERM: vperm_model = data;
            default: ;
        endcase
    endtask

    task automatic set_perms(input logic [PERM_W-1:0] h, input logic [PERM_W-1:0] v);
        write_reg(CFG_HPERM, h);
        write_reg(CFG_VPERM, v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_sweeps(input int n_items);
        int count;
        int width;
        int rows;
        t_porous_cell c;
        count = 0;
        while (count < n_items) begin
            if ($urandom_range(0, 9) < 7) begin
                width = ($urandom_range(0, 9) == 0) ? $urandom_range(200, MAX_COLS)
                                                    : $urandom_range(2, 24);
                rows = $urandom_range(1, 4);
                for (int r = 0; r < rows && count < n_items; r++) begin
                    for (int col = 0; col < width && count < n_items; col++) begin
                        c = rand_cell(col);
                        if (col == width - 1 && $urandom_range(0, 1) == 0) begin
                            c.right_open = 1'b0;
                        end
                        send_cell(c);
                        count++;
                    end
                end
            end else begin
                send_cell(rand_cell($urandom_range(0, MAX_COLS - 1)));
                count++;
            end
        end
    endtask

    task automatic test_reset_perms();
        send_cell(flat_cell(0, SAT_ZERO, SAT_ZERO, SAT_ZERO, 1'b1, 1'b1));
        send_cell(flat_cell(1, SAT_MAX, SAT_MAX, SAT_MAX, 1'b1, 1'b1));
        send_cell(flat_cell(2, SAT_MAX, SAT_ZERO, SAT_ZERO, 1'b1, 1'b1));
        send_cell(flat_cell(3, SAT_ZERO, SAT_MAX, SAT_MAX, 1'b1, 1'b1));
        send_cell(flat_cell(4, SAT_ZERO, SAT_MAX, SAT_MAX, 1'b0, 1'b0));
        send_cell(flat_cell(5, 17'd20000, 17'd60000, SAT_ZERO, 1'b1, 1'b0));
        send_cell(flat_cell(6, 17'd20000, SAT_ZERO, 17'd60000, 1'b0, 1'b1));
        send_cell(flat_cell(MAX_COLS - 1, 17'd30000, 17'd30000, 17'd30000, 1'b1, 1'b1));
        send_cell(flat_cell(0, 17'd10000, 17'd50000, 17'd40000, 1'b1, 1'b1));
        send_cell(flat_cell(0, 17'd10000, 17'd10000, 17'd10000, 1'b1, 1'b1));
        send_cell(flat_cell(3, 17'd40000, SAT_ZERO, SAT_ZERO, 1'b1, 1'b1));
        send_cell(rand_cell(7));
        send_cell(rand_cell(MAX_COLS - 1));
        drain_results();
    endtask

    task automatic test_extreme_perms();
        set_perms(16'hFFFF, 16'hFFFF);
        send_cell(flat_cell(8, SAT_ZERO, SAT_MAX, SAT_MAX, 1'b1, 1'b1));
        send_cell(flat_cell(9, SAT_MAX, SAT_ZERO, SAT_ZERO, 1'b1, 1'b1));
        send_cell(flat_cell(8, SAT_MAX, SAT_ZERO, SAT_MAX, 1'b1, 1'b1));
        send_cell(rand_cell(9));
        drain_results();
        set_perms(16'h0000, 16'h0000);
        send_cell(flat_cell(10, SAT_ZERO, SAT_MAX, SAT_MAX, 1'b1, 1'b1));
        send_cell(flat_cell(10, SAT_MAX, SAT_ZERO, SAT_ZERO, 1'b1, 1'b1));
        drain_results();
        set_perms(16'd32768, 16'd32768);
        send_cell(flat_cell(11, SAT_ZERO, SAT_MAX, SAT_MAX, 1'b1, 1'b1));
        send_cell(flat_cell(11, SAT_MAX, SAT_ZERO, SAT_ZERO, 1'b1, 1'b1));
        send_cell(rand_cell(12));
        drain_results();
    endtask

    task automatic test_spare_index();
        write_reg(CFG_HPERM, 16'd1000);
        write_reg(CFG_SPARE_2, 16'hFFFF);
        write_reg(CFG_SPARE_3, 16'h5555);
        write_reg(CFG_VPERM, 16'd2000);
        i_cfg_valid <= 1'b0;
        for (int i = 0; i < 6; i++) begin
            send_cell(rand_cell(i));
        end
        drain_results();
    endtask

    task automatic test_perm_settings();
        logic [PERM_W-1:0] h_list [8];
        logic [PERM_W-1:0] v_list [8];
        h_list = '{16'd26214, 16'd0, 16'd32768, 16'hFFFF, 16'd0, 16'd32768,
                   16'd0, 16'd0};
        v_list = '{16'd6554, 16'd0, 16'd32768, 16'hFFFF, 16'd32768, 16'd0,
                   16'd0, 16'd0};
        h_list[6] = PERM_W'($urandom_range(0, 32768));
        v_list[6] = PERM_W'($urandom_range(0, 32768));
        h_list[7] = PERM_W'($urandom_range(0, 65535));
        v_list[7] = PERM_W'($urandom_range(0, 65535));
        for (int i = 0; i < 8; i++) begin
            set_perms(h_list[i], v_list[i]);
            run_sweeps(210);
            drain_results();
        end
    endtask

    task automatic test_output_stall();
        set_perms(HPERM_RESET, VPERM_RESET);
        rx_hold = HOLD_CYCLES;
        no_idle = 1'b1;
        for (int i = 0; i < 40; i++) begin
            send_cell(rand_cell(i % 16));
        end
        no_idle = 1'b0;
        drain_results();
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        run_sweeps(150);
        no_idle = 1'b0;
        drain_results();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_perms();
        test_extreme_perms();
        test_spare_index();
        test_perm_settings();
        test_output_stall();
        test_back_to_back();
        repeat (END_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
